// ----- sv/mpe_zone_channel_allocator_assert.svh -----
`ifndef MPE_ZONE_CHANNEL_ALLOCATOR_ASSERT_SVH
`define MPE_ZONE_CHANNEL_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define MZA_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("allocator assertion failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define MZA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("allocator assertion failed");

`endif

// ----- sv/mza_pkg.sv -----
package mza_pkg;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 7;

  localparam logic [CFG_INDEX_W-1:0] REG_ZONE_COUNT    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_NOTE_VELOCITY = 2'd1;

  localparam logic REQ_NOTE_START = 1'b0;
  localparam logic REQ_NOTE_END   = 1'b1;

  localparam logic [3:0] STATUS_NOTE_ON  = 4'h9;
  localparam logic [3:0] STATUS_NOTE_OFF = 4'h8;

  localparam logic signed [7:0] OCC_MAX = 8'sd127;
  localparam logic signed [7:0] OCC_MIN = -8'sd128;
  localparam logic signed [7:0] OCC_ONE = 8'sd1;

  typedef struct packed {
    logic clear;
    logic acq_scan;
    logic acq_first;
    logic acq_commit;
    logic rel_scan;
  } occ_ctrl_t;

endpackage

// ----- sv/mza_zone_map.sv -----
module mza_zone_map import mza_pkg::*; #(
  parameter int CHANNELS  = 16,
  parameter int MAX_ZONES = 8,
  parameter int CW        = $clog2(CHANNELS),
  parameter int ZW        = (MAX_ZONES > 1) ? $clog2(MAX_ZONES) : 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          count_we,
  input  logic [3:0]    count_value,
  input  logic [2:0]    zone_index,
  output logic [ZW-1:0] zone_sel,
  output logic [CW-1:0] zone_first,
  output logic [CW-1:0] zone_span
);

  logic [2:0]    count_tab [16];
  logic [ZW-1:0] sel_tab   [8][8];
  logic [CW-1:0] base_tab  [8][MAX_ZONES];
  logic [CW-1:0] span_tab  [8][MAX_ZONES];
  logic [2:0]    count_m1;

  for (genvar v = 0; v < 16; v++) begin : g_count
    localparam int M0 = v % (MAX_ZONES + 1);
    localparam int M1 = (M0 == 0) ? 1 : M0;
    localparam int NZ = (M1 > CHANNELS / 2) ? CHANNELS / 2 : M1;
    assign count_tab[v] = 3'(NZ - 1);
  end

  for (genvar n = 1; n <= 8; n++) begin : g_rows
    localparam int Q = CHANNELS / n;
    localparam int R = CHANNELS % n;
    for (genvar i = 0; i < 8; i++) begin : g_sel
      localparam int ZS = i % n;
      assign sel_tab[n-1][i] = ZW'(ZS);
    end
    for (genvar z = 0; z < MAX_ZONES; z++) begin : g_zone
      localparam int BASE = z * Q + ((z < R) ? z : R);
      localparam int SPAN = Q - 1 + ((z < R) ? 1 : 0);
      assign base_tab[n-1][z] = CW'(BASE);
      assign span_tab[n-1][z] = CW'(SPAN);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count_m1 <= 3'd0;
    end else if (count_we) begin
      count_m1 <= count_tab[count_value];
    end
  end

  assign zone_sel   = sel_tab[count_m1][zone_index];
  assign zone_first = CW'(base_tab[count_m1][zone_sel] + 1'b1);
  assign zone_span  = span_tab[count_m1][zone_sel];

endmodule

// ----- sv/mza_occ_unit.sv -----
module mza_occ_unit import mza_pkg::*; #(
  parameter int CHANNELS = 16,
  parameter int CW       = $clog2(CHANNELS)
) (
  input  logic          clk,
  input  logic          rst,
  input  occ_ctrl_t     ctrl,
  input  logic [CW-1:0] addr,
  input  logic [CW-1:0] off,
  input  logic [CW-1:0] rel_ch,
  output logic [CW-1:0] best_pos
);

  logic signed [7:0] occ [CHANNELS];
  logic signed [7:0] best;
  logic signed [7:0] rd;
  logic signed [7:0] cmp_ref;
  logic              lower;
  logic              drop;

  assign rd      = occ[addr];
  assign cmp_ref = ctrl.acq_first ? OCC_MAX : best;
  assign lower   = rd < cmp_ref;
  assign drop    = ((addr == rel_ch) || (rd <= 8'sd0)) && (rd != OCC_MIN);

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      for (int c = 0; c < CHANNELS; c++) begin
        occ[c] <= 8'sd0;
      end
    end else if (ctrl.acq_commit) begin
      if (rd <= 8'sd0) begin
        occ[addr] <= OCC_ONE;
      end else if (rd < OCC_MAX) begin
        occ[addr] <= rd + OCC_ONE;
      end
    end else if (ctrl.rel_scan && drop) begin
      occ[addr] <= rd - OCC_ONE;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.acq_scan) begin
      if (ctrl.acq_first) begin
        best     <= lower ? rd : OCC_MAX;
        best_pos <= off;
      end else if (lower) begin
        best     <= rd;
        best_pos <= off;
      end
    end
  end

endmodule

// ----- sv/mpe_zone_channel_allocator.sv -----
// Channel   Handshake              Payload
// in        in_valid / in_stall    req_type, zone_index, note_key, voice_channel
// out       out_valid / out_stall  status_byte, key_byte, velocity_byte, chosen_channel
// cfg       cfg_we                 cfg_index, cfg_data
//
// A note start scans the zone's voice channels, commits a choice and presents the result;
// a note end scans them and presents one. A zone has at most CHANNELS - 1 voice channels;
// the scan visits one channel per cycle; input is ready again when the result is presented.
// Reset clears occupancy and search pointers and selects one zone; a zone count write clears
// them as well and takes effect at its write edge.
// While a result is stalled the next transaction is accepted and held in its last step.
module mpe_zone_channel_allocator import mza_pkg::*; #(
  parameter int CHANNELS  = 16,
  parameter int MAX_ZONES = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   req_type,
  input  logic [2:0]             zone_index,
  input  logic [6:0]             note_key,
  input  logic [3:0]             voice_channel,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [7:0]             status_byte,
  output logic [6:0]             key_byte,
  output logic [6:0]             velocity_byte,
  output logic [3:0]             chosen_channel,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int CW = $clog2(CHANNELS);
  localparam int ZW = (MAX_ZONES > 1) ? $clog2(MAX_ZONES) : 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ACQ_SCAN,
    S_ACQ_COMMIT,
    S_REL_SCAN,
    S_DONE
  } state_t;

  state_t        state;
  logic [CW-1:0] ch_mod_tab [16];
  logic          zc_we;
  logic [ZW-1:0] zone_sel_in;
  logic [CW-1:0] zone_first_in;
  logic [CW-1:0] zone_span_in;
  logic [CW-1:0] search_start [MAX_ZONES];
  logic [6:0]    velocity;
  logic          req_end;
  logic [6:0]    key;
  logic [ZW-1:0] zsel;
  logic [CW-1:0] first;
  logic [CW-1:0] span;
  logic [CW-1:0] k;
  logic [CW-1:0] off;
  logic [CW-1:0] off_inc;
  logic [CW-1:0] rel_ch;
  logic [CW-1:0] res_ch;
  logic [CW-1:0] addr;
  logic [CW-1:0] best_pos;
  logic [CW-1:0] pos_inc;
  logic          last;
  occ_ctrl_t     occ_ctrl;

  for (genvar v = 0; v < 16; v++) begin : g_ch_mod
    localparam int CM = v % CHANNELS;
    assign ch_mod_tab[v] = CW'(CM);
  end

  assign zc_we    = cfg_we && (cfg_index == REG_ZONE_COUNT);
  assign in_stall = rst || (state != S_IDLE);
  assign off_inc  = CW'(off + 1'b1);
  assign pos_inc  = CW'(best_pos + 1'b1);
  assign last     = (k == CW'(span - 1'b1));

  mza_zone_map #(
    .CHANNELS  (CHANNELS),
    .MAX_ZONES (MAX_ZONES),
    .CW        (CW),
    .ZW        (ZW)
  ) u_zone_map (
    .clk         (clk),
    .rst         (rst),
    .count_we    (zc_we),
    .count_value (cfg_data[3:0]),
    .zone_index  (zone_index),
    .zone_sel    (zone_sel_in),
    .zone_first  (zone_first_in),
    .zone_span   (zone_span_in)
  );

  always_comb begin
    occ_ctrl       = '0;
    occ_ctrl.clear = zc_we;
    addr           = CW'(first + off);
    unique case (state)
      S_ACQ_SCAN: begin
        occ_ctrl.acq_scan  = 1'b1;
        occ_ctrl.acq_first = (k == '0);
      end
      S_ACQ_COMMIT: begin
        occ_ctrl.acq_commit = 1'b1;
        addr                = CW'(first + best_pos);
      end
      S_REL_SCAN: begin
        occ_ctrl.rel_scan = 1'b1;
        addr              = CW'(first + k);
      end
      default: begin
      end
    endcase
  end

  mza_occ_unit #(
    .CHANNELS (CHANNELS),
    .CW       (CW)
  ) u_occ_unit (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (occ_ctrl),
    .addr     (addr),
    .off      (off),
    .rel_ch   (rel_ch),
    .best_pos (best_pos)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      velocity  <= '0;
      for (int z = 0; z < MAX_ZONES; z++) begin
        search_start[z] <= '0;
      end
    end else begin
      if (cfg_we && (cfg_index == REG_NOTE_VELOCITY)) begin
        velocity <= cfg_data;
      end
      if (out_valid && !out_stall && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            req_end <= req_type;
            key     <= note_key;
            zsel    <= zone_sel_in;
            first   <= zone_first_in;
            span    <= zone_span_in;
            off     <= search_start[zone_sel_in];
            rel_ch  <= ch_mod_tab[voice_channel];
            res_ch  <= ch_mod_tab[voice_channel];
            k       <= '0;
            state   <= (req_type == REQ_NOTE_END) ? S_REL_SCAN : S_ACQ_SCAN;
          end
        end
        S_ACQ_SCAN: begin
          k   <= CW'(k + 1'b1);
          off <= (off_inc == span) ? '0 : off_inc;
          if (last) begin
            state <= S_ACQ_COMMIT;
          end
        end
        S_ACQ_COMMIT: begin
          res_ch             <= addr;
          search_start[zsel] <= (pos_inc == span) ? '0 : pos_inc;
          state              <= S_DONE;
        end
        S_REL_SCAN: begin
          k <= CW'(k + 1'b1);
          if (last) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid      <= 1'b1;
            status_byte    <= {(req_end ? STATUS_NOTE_OFF : STATUS_NOTE_ON), 4'(res_ch)};
            key_byte       <= key;
            velocity_byte  <= req_end ? 7'd0 : velocity;
            chosen_channel <= 4'(res_ch);
            state          <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (zc_we) begin
        for (int z = 0; z < MAX_ZONES; z++) begin
          search_start[z] <= '0;
        end
      end
    end
  end

endmodule

// ----- sv/mza_checker.sv -----
`include "mpe_zone_channel_allocator_assert.svh"

module mza_checker import mza_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] status_byte,
  input logic [6:0] velocity_byte,
  input logic [3:0] chosen_channel
);

  // Every accepted transaction occupies the sequencer and stalls the input behind it.
  `MZA_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && !in_stall, in_stall)

  // The status byte carries the same channel as the channel field.
  `MZA_ASSERT_SAME(a_status_channel, clk, rst, out_valid, status_byte[3:0] == chosen_channel)

  // A note-off always goes out with zero velocity.
  `MZA_ASSERT_SAME(a_off_velocity, clk, rst,
    out_valid && (status_byte[7:4] == STATUS_NOTE_OFF), velocity_byte == 7'd0)

  // A stalled result stays presented and unchanged.
  `MZA_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall,
    out_valid && $stable(status_byte) && $stable(chosen_channel))

endmodule

bind mpe_zone_channel_allocator mza_checker u_mza_checker (.*);

// ----- bench/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import mza_pkg::*;

  localparam int NUM_CHANNELS = 16;
  localparam int NUM_ZONES = 8;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 40;

  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_B = 2'd3;

  typedef struct packed {
    logic       req;
    logic [2:0] zone;
    logic [6:0] key;
    logic [3:0] chan;
  } note_req_t;

  typedef struct packed {
    logic [7:0] status;
    logic [6:0] key;
    logic [6:0] vel;
    logic [3:0] chan;
  } note_msg_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic req_type = 1'b0;
  logic [2:0] zone_index = '0;
  logic [6:0] note_key = '0;
  logic [3:0] voice_channel = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [7:0] status_byte;
  logic [6:0] key_byte;
  logic [6:0] velocity_byte;
  logic [3:0] chosen_channel;
  logic cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  note_req_t pending_reqs[$];
  note_msg_t awaited_msgs[$];
  int errors = 0;
  int send_gap = 0;
  int stall_left = 0;
  logic hold_req = 1'b0;
  logic hold_done = 1'b0;
  logic calm = 1'b0;

  logic signed [7:0] chan_load[NUM_CHANNELS];
  logic [3:0] zone_first[NUM_ZONES];
  logic [3:0] zone_voices[NUM_ZONES];
  logic [3:0] zone_cursor[NUM_ZONES];
  int zone_total;
  logic [6:0] on_velocity;

  mpe_zone_channel_allocator #(
    .CHANNELS(NUM_CHANNELS),
    .MAX_ZONES(NUM_ZONES)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .req_type(req_type),
    .zone_index(zone_index),
    .note_key(note_key),
    .voice_channel(voice_channel),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status_byte(status_byte),
    .key_byte(key_byte),
    .velocity_byte(velocity_byte),
    .chosen_channel(chosen_channel),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  function automatic void rebuild_zones(logic [3:0] v);
    int n, spare, base_span, at;
    n = v % (NUM_ZONES + 1);
    if (n == 0) n = 1;
    if (n > NUM_CHANNELS / 2) n = NUM_CHANNELS / 2;
    zone_total = n;
    spare = NUM_CHANNELS % n;
    base_span = (NUM_CHANNELS - spare) / n - 1;
    at = 0;
    for (int z = 0; z < n; z++) begin
      zone_first[z] = 4'(at);
      zone_cursor[z] = '0;
      zone_voices[z] = 4'(base_span + (spare > 0 ? 1 : 0));
      if (spare > 0) spare--;
      at += 1 + zone_voices[z];
    end
    foreach (chan_load[c]) chan_load[c] = '0;
  endfunction

  function automatic note_msg_t allocate_message(note_req_t r);
    note_msg_t m;
    int zone, first, span, start, pos, off, c, ch;
    logic signed [7:0] best;
    zone = r.zone % zone_total;
    first = zone_first[zone] + 1;
    span = zone_voices[zone];
    if (r.req == REQ_NOTE_START) begin
      start = zone_cursor[zone];
      pos = start % span;
      best = OCC_MAX;
      for (int k = 0; k < span; k++) begin
        off = (start + k) % span;
        c = (first + off) % NUM_CHANNELS;
        if (chan_load[c] < best) begin
          best = chan_load[c];
          pos = off;
        end
      end
      ch = (first + pos) % NUM_CHANNELS;
      if (chan_load[ch] <= 8'sd0) chan_load[ch] = OCC_ONE;
      else if (chan_load[ch] < OCC_MAX) chan_load[ch] = chan_load[ch] + 8'sd1;
      zone_cursor[zone] = 4'((pos + 1) % span);
      m.status = {STATUS_NOTE_ON, 4'(ch)};
      m.vel = on_velocity;
    end else begin
      ch = r.chan;
      for (int k = 0; k < span; k++) begin
        c = (first + k) % NUM_CHANNELS;
        if ((c == ch || chan_load[c] <= 8'sd0) && chan_load[c] > OCC_MIN) begin
          chan_load[c] = chan_load[c] - 8'sd1;
        end
      end
      m.status = {STATUS_NOTE_OFF, 4'(ch)};
      m.vel = '0;
    end
    m.key = r.key;
    m.chan = 4'(ch);
    return m;
  endfunction

  always @(posedge clk) begin : driver
    note_req_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        awaited_msgs.push_back(allocate_message({req_type, zone_index, note_key, voice_channel}));
      end
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          in_valid <= 1'b0;
          send_gap <= send_gap - 1;
        end else if (pending_reqs.size() > 0) begin
          nxt = pending_reqs.pop_front();
          in_valid <= 1'b1;
          req_type <= nxt.req;
          zone_index <= nxt.zone;
          note_key <= nxt.key;
          voice_channel <= nxt.chan;
          if (!calm && $urandom_range(0, 7) == 0) send_gap <= $urandom_range(1, 10);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : monitor
    note_msg_t want;
    if (rst) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (awaited_msgs.size() == 0) begin
          $error("unexpected transaction: status_byte %0h, chosen_channel %0d",
                 status_byte, chosen_channel);
          errors++;
        end else begin
          want = awaited_msgs.pop_front();
          if (status_byte !== want.status) begin
            $error("status_byte: expected %0h, got %0h", want.status, status_byte);
            errors++;
          end
          if (key_byte !== want.key) begin
            $error("key_byte: expected %0d, got %0d", want.key, key_byte);
            errors++;
          end
          if (velocity_byte !== want.vel) begin
            $error("velocity_byte: expected %0d, got %0d", want.vel, velocity_byte);
            errors++;
          end
          if (chosen_channel !== want.chan) begin
            $error("chosen_channel: expected %0d, got %0d", want.chan, chosen_channel);
            errors++;
          end
        end
      end
      if (hold_req && !hold_done) begin
        hold_done <= 1'b1;
        stall_left <= HOLD_CYCLES;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_stall <= 1'b1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        stall_left <= $urandom_range(0, 9);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    if (idx == REG_ZONE_COUNT) rebuild_zones(data[3:0]);
    else if (idx == REG_NOTE_VELOCITY) on_velocity = data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic add_req(logic req, logic [2:0] zone, logic [6:0] key, logic [3:0] chan);
    pending_reqs.push_back({req, zone, key, chan});
  endtask

  task automatic queue_random(int start_pct, int hot);
    logic [2:0] z;
    logic [3:0] ch;
    logic is_start;
    int eff;
    do z = 3'($urandom_range(0, 7)); while (hot >= 0 && z % zone_total != hot);
    eff = z % zone_total;
    is_start = $urandom_range(0, 99) < start_pct;
    if (is_start || $urandom_range(0, 4) == 0) begin
      ch = 4'($urandom);
    end else begin
      ch = 4'(zone_first[eff] + 1 + $urandom_range(0, zone_voices[eff] - 1));
    end
    add_req(is_start ? REQ_NOTE_START : REQ_NOTE_END, z, 7'($urandom), ch);
  endtask

  task automatic wait_drained();
    do @(negedge clk); while (pending_reqs.size() != 0 || in_valid || awaited_msgs.size() != 0);
  endtask

  task automatic run_phase(logic [CFG_DATA_W-1:0] zones, logic [CFG_DATA_W-1:0] vel,
                           int count, int start_pct, int hot);
    write_reg(REG_NOTE_VELOCITY, vel);
    write_reg(REG_ZONE_COUNT, zones);
    repeat (count) queue_random(start_pct, hot);
    wait_drained();
  endtask

  initial begin
    foreach (zone_first[z]) begin
      zone_first[z] = '0;
      zone_voices[z] = '0;
      zone_cursor[z] = '0;
    end
    on_velocity = '0;
    rebuild_zones(4'd1);

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    add_req(REQ_NOTE_START, 3'd0, 7'd0, 4'd0);
    add_req(REQ_NOTE_START, 3'd7, 7'd127, 4'd15);
    add_req(REQ_NOTE_START, 3'd3, 7'd60, 4'd9);
    add_req(REQ_NOTE_END, 3'd0, 7'd60, 4'd2);
    add_req(REQ_NOTE_END, 3'd5, 7'd0, 4'd0);
    add_req(REQ_NOTE_END, 3'd0, 7'd127, 4'd15);
    wait_drained();

    write_reg(REG_NOTE_VELOCITY, 7'h7F);
    write_reg(REG_ZONE_COUNT, 7'h7F);
    write_reg(REG_SPARE_A, 7'h55);
    write_reg(REG_SPARE_B, 7'h2A);
    add_req(REQ_NOTE_START, 3'd7, 7'd1, 4'd0);
    add_req(REQ_NOTE_START, 3'd7, 7'd2, 4'd0);
    add_req(REQ_NOTE_START, 3'd1, 7'd3, 4'd0);
    add_req(REQ_NOTE_START, 3'd5, 7'd4, 4'd0);
    add_req(REQ_NOTE_START, 3'd5, 7'd5, 4'd0);
    add_req(REQ_NOTE_END, 3'd5, 7'd5, 4'd15);
    add_req(REQ_NOTE_END, 3'd2, 7'd126, 4'd3);
    wait_drained();

    write_reg(REG_ZONE_COUNT, 7'd0);
    write_reg(REG_ZONE_COUNT, 7'd9);
    add_req(REQ_NOTE_START, 3'd6, 7'd64, 4'd0);
    add_req(REQ_NOTE_END, 3'd1, 7'd64, 4'd8);
    wait_drained();

    write_reg(REG_NOTE_VELOCITY, 7'd0);
    write_reg(REG_ZONE_COUNT, 7'd8);
    add_req(REQ_NOTE_START, 3'd7, 7'd127, 4'd0);
    add_req(REQ_NOTE_END, 3'd7, 7'd127, 4'd15);
    add_req(REQ_NOTE_END, 3'd0, 7'd0, 4'd0);
    wait_drained();

    run_phase({3'($urandom), 4'd8}, 7'd127, 120, 60, -1);
    run_phase({3'($urandom), 4'd7}, 7'($urandom), 270, 98, 0);
    run_phase({3'($urandom), 4'd8}, 7'd0, 140, 3, 1);
    hold_req = 1'b1;
    run_phase(7'($urandom), 7'($urandom), 110, 55, -1);
    run_phase({3'($urandom), 4'd1}, 7'($urandom), 110, 55, -1);
    run_phase({3'($urandom), 4'd3}, 7'($urandom), 110, 50, -1);
    calm = 1'b1;
    run_phase(7'($urandom), 7'($urandom), 120, 55, -1);

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("mpe_zone_channel_allocator verification clean");
    end else begin
      $display("mpe_zone_channel_allocator verification failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("mpe_zone_channel_allocator verification failed");
    $finish;
  end

endmodule
